// File: hdl/esd_pkg.sv
// ============================================================================
// Escape sequence decoder package
// Character codes, the result record and the hex digit decode shared by the
// escape sequence decoder.
// ============================================================================
package esd_pkg;

    // One decoded result as it sits in the output queue.
    typedef struct packed {
        logic [7:0] decoded_char;
        logic       end_mark;
        logic       last_of_run;
    } result_t;

    // Hex digit decode: a valid flag and the digit value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Escape introducers.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    // Letters after a backslash.
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_UC_E   = 8'h45;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_QUOTE  = 8'h27;

    // Digit and letter ranges.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    // Decoded control characters.
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_FF    = 8'h0C;
    localparam logic [7:0] ESC_CHAR   = 8'h1B;
    localparam logic [7:0] CTRL_MASK  = 8'h1F;

    // Map an ASCII byte to its hex digit value, if it is one.
    function automatic hex_digit_t hex_digit(input logic [7:0] b);
        hex_digit_t d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            diff    = b - CH_ZERO;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (b >= CH_LC_A && b <= CH_LC_F) begin
            diff    = b - CH_LC_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (b >= CH_UC_A && b <= CH_UC_F) begin
            diff    = b - CH_UC_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end
        return d;
    endfunction

endpackage

// File: hdl/escape_sequence_decoder.sv
// A byte goes from the input stage register to the result queue, whose head drives m_*.
// Throughput: one byte per cycle while the result queue has room; a byte that closes a
// number and is a plain character gives two results, one at a time on the single result port.
// Reset (aresetn low, synchronous) empties the input stage and the result queue and
// returns the decoder to plain mode with a zero accumulator.
// ============================================================================
// Escape sequence decoder
// Decodes caret, backslash, hex and octal escapes in a byte stream and emits
// the decoded characters plus an end mark at end of stream.
// ============================================================================
module escape_sequence_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tuser,   // [0] end_of_stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] decoded_char
    output logic       m_tuser,   // [0] end_mark
    output logic       m_tlast    // last_of_run
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_CARET  = 3'd1,
        MODE_BSLASH = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT    = 3'd4
    } mode_t;

    // Decoder state.
    mode_t      mode_reg, mode_next;
    logic [7:0] num_reg, num_next;
    logic       stop_reg, stop_next;

    // Input stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // Result queue, two entries, head at index 0.
    result_t    q_reg [2];
    result_t    q_next [2];
    logic [1:0] cnt_reg, cnt_next;

    // Decode results for the byte in the input stage.
    result_t    r0, r1;
    logic [1:0] need_cnt;
    logic [1:0] push_cnt;
    logic [1:0] cnt_mid;
    logic       consume;
    logic       pop;
    logic       idx0;

    // Plain-mode handling of the current byte.
    logic       plain_emit;
    mode_t      plain_mode;
    hex_digit_t hd;
    logic       is_digit;
    logic [7:0] digit_off;

    logic [7:0] b;
    assign b = in_byte_reg;

    always_comb begin
        hd        = hex_digit(b);
        is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
        digit_off = b - CH_ZERO;
        if (b == CH_BSLASH) begin
            plain_emit = 1'b0;
            plain_mode = MODE_BSLASH;
        end else if (b == CH_CARET) begin
            plain_emit = 1'b0;
            plain_mode = MODE_CARET;
        end else begin
            plain_emit = 1'b1;
            plain_mode = MODE_PLAIN;
        end
    end

    // Next state and the up to two results for this byte.
    always_comb begin
        mode_next = mode_reg;
        num_next  = num_reg;
        stop_next = stop_reg;
        need_cnt  = 2'd0;
        r0        = '{decoded_char: b, end_mark: 1'b0, last_of_run: 1'b1};
        r1        = '{decoded_char: b, end_mark: 1'b0, last_of_run: 1'b1};
        if (in_eos_reg) begin
            // End of stream drops any pending escape.
            mode_next = MODE_PLAIN;
            num_next  = '0;
            stop_next = 1'b0;
            need_cnt  = 2'd1;
            r0        = '{decoded_char: 8'h00, end_mark: 1'b1, last_of_run: 1'b1};
        end else begin
            unique case (mode_reg)
                MODE_CARET: begin
                    mode_next       = MODE_PLAIN;
                    need_cnt        = 2'd1;
                    r0.decoded_char = b & CTRL_MASK;
                end
                MODE_BSLASH: begin
                    mode_next = MODE_PLAIN;
                    need_cnt  = 2'd1;
                    case (b) inside
                        CH_LC_N:          r0.decoded_char = CODE_LF;
                        CH_LC_T:          r0.decoded_char = CODE_TAB;
                        CH_LC_B:          r0.decoded_char = CODE_BS;
                        CH_LC_R:          r0.decoded_char = CODE_CR;
                        CH_LC_S:          r0.decoded_char = CODE_SPACE;
                        CH_LC_F:          r0.decoded_char = CODE_FF;
                        CH_LC_E, CH_UC_E: r0.decoded_char = ESC_CHAR;
                        CH_LC_X: begin
                            mode_next = MODE_HEX;
                            num_next  = '0;
                            need_cnt  = 2'd0;
                        end
                        default: begin
                            // Backslash, quote and unknown non-digit escapes give the byte itself; a digit opens octal.
                            if (is_digit) begin
                                mode_next = MODE_OCT;
                                need_cnt  = 2'd0;
                                if (b <= CH_SEVEN) begin
                                    num_next  = digit_off;
                                    stop_next = 1'b0;
                                end else begin
                                    num_next  = '0;
                                    stop_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (hd.valid) begin
                        num_next = {num_reg[3:0], hd.value};
                    end else begin
                        // The terminating byte flushes the number, then acts as plain.
                        num_next        = '0;
                        mode_next       = plain_mode;
                        r0.decoded_char = num_reg;
                        r0.last_of_run  = !plain_emit;
                        need_cnt        = plain_emit ? 2'd2 : 2'd1;
                    end
                end
                MODE_OCT: begin
                    if (is_digit) begin
                        if (!stop_reg && b <= CH_SEVEN) begin
                            num_next = {num_reg[4:0], digit_off[2:0]};
                        end else begin
                            stop_next = 1'b1;
                        end
                    end else begin
                        num_next        = '0;
                        stop_next       = 1'b0;
                        mode_next       = plain_mode;
                        r0.decoded_char = num_reg;
                        r0.last_of_run  = !plain_emit;
                        need_cnt        = plain_emit ? 2'd2 : 2'd1;
                    end
                end
                default: begin
                    mode_next = plain_mode;
                    need_cnt  = plain_emit ? 2'd1 : 2'd0;
                end
            endcase
        end
    end

    // Handshake: the byte leaves the input stage once the queue has room for all its results.
    assign pop      = m_tvalid && m_tready;
    assign consume  = in_valid_reg && (need_cnt <= (2'd2 - cnt_reg));
    assign push_cnt = consume ? need_cnt : 2'd0;
    assign s_tready = !in_valid_reg || consume;

    // Result queue update: pop the head, then append the new results.
    always_comb begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        cnt_mid   = pop ? (cnt_reg - 2'd1) : cnt_reg;
        idx0      = cnt_mid[0];
        if (pop) begin
            q_next[0] = q_reg[1];
        end
        if (push_cnt != 2'd0) begin
            q_next[idx0] = r0;
        end
        if (push_cnt == 2'd2) begin
            q_next[1] = r1;
        end
        cnt_next = cnt_mid + push_cnt;
    end

    // Control state, input stage and queue registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_PLAIN;
            num_reg      <= '0;
            stop_reg     <= 1'b0;
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            if (consume) begin
                mode_reg <= mode_next;
                num_reg  <= num_next;
                stop_reg <= stop_next;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tuser;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    // Result port shows the queue head.
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].decoded_char;
    assign m_tuser  = q_reg[0].end_mark;
    assign m_tlast  = q_reg[0].last_of_run;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Escape sequence decoder testbench
// Drives text bytes and end-of-stream requests into the decoder and checks
// every decoded result against a cycle-free predictor of the decode rules.
// A short directed pass hits the escape corner cases. Random escape, number
// and noise sequences follow, with random gaps on both sides, a stretch
// without gaps, and one long result stall that backs up the input side.
// ============================================================================
module testbench;

    import esd_pkg::*;

    // Decoder modes tracked by the predictor.
    typedef enum logic [2:0] {
        DM_PLAIN  = 3'd0,
        DM_CARET  = 3'd1,
        DM_BSLASH = 3'd2,
        DM_HEX    = 3'd3,
        DM_OCT    = 3'd4
    } decode_mode_t;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_STALL   = 300;
    localparam int DRAIN_CYCLES = 10;

    // Letters that form a simple backslash escape.
    localparam logic [7:0] ESC_LETTERS [10] = '{
        CH_LC_N, CH_LC_T, CH_LC_B, CH_LC_R, CH_LC_S,
        CH_LC_F, CH_LC_E, CH_UC_E, CH_BSLASH, CH_QUOTE
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
    logic       s_tuser  = 1'b0;    // [0] end_of_stream
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] decoded_char
    logic       m_tuser;            // [0] end_mark
    logic       m_tlast;

    // Predictor state.
    decode_mode_t dec_mode   = DM_PLAIN;
    logic [7:0]   num_acc    = 8'h00;
    logic         oct_halted = 1'b0;

    result_t expected_chars [$];
    int      error_count     = 0;
    int      items_sent      = 0;
    int      cycle_count     = 0;
    bit      idle_on         = 1'b1;
    bit      long_stall_req  = 1'b0;

    escape_sequence_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void emit_char(input logic [7:0] ch);
        result_t r;
        r.decoded_char = ch;
        r.end_mark     = 1'b0;
        r.last_of_run  = 1'b0;
        expected_chars.push_back(r);
    endfunction

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] off;
        off = 8'h00;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            off = b - CH_ZERO;
            return {1'b1, off[3:0]};
        end
        if (b >= CH_LC_A && b <= CH_LC_F) begin
            off = b - CH_LC_A + 8'd10;
            return {1'b1, off[3:0]};
        end
        if (b >= CH_UC_A && b <= CH_UC_F) begin
            off = b - CH_UC_A + 8'd10;
            return {1'b1, off[3:0]};
        end
        return 5'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // A byte seen in plain mode: either opens an escape or passes through.
    function automatic void take_plain(input logic [7:0] b);
        dec_mode = DM_PLAIN;
        if (b == CH_BSLASH) begin
            dec_mode = DM_BSLASH;
        end else if (b == CH_CARET) begin
            dec_mode = DM_CARET;
        end else begin
            emit_char(b);
        end
    endfunction

    // The byte right after a backslash.
    function automatic void take_escape(input logic [7:0] b);
        dec_mode = DM_PLAIN;
        case (b)
            CH_LC_N:            emit_char(CODE_LF);
            CH_LC_T:            emit_char(CODE_TAB);
            CH_LC_B:            emit_char(CODE_BS);
            CH_LC_R:            emit_char(CODE_CR);
            CH_LC_S:            emit_char(CODE_SPACE);
            CH_LC_F:            emit_char(CODE_FF);
            CH_LC_E, CH_UC_E:   emit_char(ESC_CHAR);
            CH_BSLASH:          emit_char(CH_BSLASH);
            CH_QUOTE:           emit_char(CH_QUOTE);
            CH_LC_X: begin
                dec_mode = DM_HEX;
                num_acc  = 8'h00;
            end
            default: begin
                if (is_digit(b)) begin
                    dec_mode = DM_OCT;
                    // A leading 8 or 9 freezes the value at zero.
                    if (b <= CH_SEVEN) begin
                        num_acc    = b - CH_ZERO;
                        oct_halted = 1'b0;
                    end else begin
                        num_acc    = 8'h00;
                        oct_halted = 1'b1;
                    end
                end else begin
                    emit_char(b);
                end
            end
        endcase
    endfunction

    // Work out the results of one accepted request and queue them.
    function automatic void predict_decode(input logic [7:0] b, input logic eos);
        int         first_new;
        logic [4:0] nib;
        result_t    mark;
        first_new = expected_chars.size();
        if (eos) begin
            // End of stream drops anything pending.
            dec_mode          = DM_PLAIN;
            num_acc           = 8'h00;
            oct_halted        = 1'b0;
            mark.decoded_char = 8'h00;
            mark.end_mark     = 1'b1;
            mark.last_of_run  = 1'b1;
            expected_chars.push_back(mark);
        end else begin
            case (dec_mode)
                DM_CARET: begin
                    dec_mode = DM_PLAIN;
                    emit_char(b & CTRL_MASK);
                end
                DM_BSLASH: take_escape(b);
                DM_HEX: begin
                    nib = hex_nibble(b);
                    if (nib[4]) begin
                        num_acc = {num_acc[3:0], nib[3:0]};
                    end else begin
                        emit_char(num_acc);
                        num_acc = 8'h00;
                        take_plain(b);
                    end
                end
                DM_OCT: begin
                    if (is_digit(b)) begin
                        if (!oct_halted && b <= CH_SEVEN) begin
                            num_acc = {num_acc[4:0], b[2:0]};
                        end else begin
                            oct_halted = 1'b1;
                        end
                    end else begin
                        emit_char(num_acc);
                        num_acc    = 8'h00;
                        oct_halted = 1'b0;
                        take_plain(b);
                    end
                end
                default: take_plain(b);
            endcase
            if (expected_chars.size() > first_new) begin
                expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one request after a random gap and predict it once it is taken.
    task automatic send_item(input logic [7:0] text_byte, input logic eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text_byte;
        s_tuser  <= eos;
        do @(posedge aclk); while (!s_tready);
        predict_decode(text_byte, eos);
        items_sent++;
    endtask

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return CH_ZERO + 8'(r);
        if (r < 16) return CH_LC_A + 8'(r - 10);
        return CH_UC_A + 8'(r - 16);
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Receiver: random stalls per result, plus one long hold-off on request.
    initial begin : receiver
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (long_stall_req) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                long_stall_req = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected result: decoded_char %0h end_mark %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.decoded_char) begin
                    $error("decoded_char: expected %0h, got %0h", want.decoded_char, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.end_mark) begin
                    $error("end_mark: expected %0b, got %0b", want.end_mark, m_tuser);
                    error_count++;
                end
                if (m_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and the escape corner cases.
    task automatic test_directed();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        // Caret masks the next byte to five bits.
        send_item(CH_CARET, 1'b0);
        send_item(8'hFF, 1'b0);
        // Caret caret.
        send_item(CH_CARET, 1'b0);
        send_item(CH_CARET, 1'b0);
        // Hex value wider than a byte, closed by a plain letter.
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_LC_X, 1'b0);
        send_item(CH_ZERO + 8'd4, 1'b0);
        send_item(CH_ZERO + 8'd1, 1'b0);
        send_item(CH_UC_F, 1'b0);
        send_item("g", 1'b0);
        // Empty hex escape closed by a backslash, then an unknown escape.
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_LC_X, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item("q", 1'b0);
        // Octal stopped by a 9; the digits after it are swallowed.
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_ZERO + 8'd1, 1'b0);
        send_item(CH_SEVEN, 1'b0);
        send_item(CH_NINE, 1'b0);
        send_item(CH_SEVEN, 1'b0);
        send_item(";", 1'b0);
        // Leading 8 gives zero.
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_SEVEN + 8'd1, 1'b0);
        send_item(CODE_SPACE, 1'b0);
        // End of stream in the middle of a caret escape.
        send_item(CH_CARET, 1'b0);
        send_item(8'hA5, 1'b1);
    endtask

    // Mostly well-formed escapes and numbers with random content, some noise.
    task automatic test_random_text(input int n_items, input bit with_idling);
        int first_item;
        int pick;
        int n_digits;
        idle_on    = with_idling;
        first_item = items_sent;
        while (items_sent - first_item < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_item(CH_BSLASH, 1'b0);
                send_item(ESC_LETTERS[$urandom_range(0, 9)], 1'b0);
            end else if (pick < 43) begin
                send_item(CH_BSLASH, 1'b0);
                send_item(CH_LC_X, 1'b0);
                n_digits = $urandom_range(0, 4);
                repeat (n_digits) send_item(random_hex_char(), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 58) begin
                send_item(CH_BSLASH, 1'b0);
                n_digits = $urandom_range(1, 5);
                repeat (n_digits) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 68) begin
                send_item(CH_CARET, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 85) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 90) begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                // Noise: stray escape openers and random bytes.
                n_digits = $urandom_range(1, 3);
                repeat (n_digits) begin
                    case ($urandom_range(0, 2))
                        0:       send_item(CH_BSLASH, 1'b0);
                        1:       send_item(CH_CARET, 1'b0);
                        default: send_item(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
            end
        end
    endtask

    // Hold the result side off while random bytes keep coming, so the block
    // backs up and drops s_tready.
    task automatic test_result_backpressure();
        idle_on        = 1'b0;
        long_stall_req = 1'b1;
        repeat (60) send_item(8'($urandom_range(0, 255)), 1'b0);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_text(480, 1'b1);
        test_result_backpressure();
        test_random_text(200, 1'b0);
        test_random_text(340, 1'b1);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
